FILE: rtl/core/lgp_pkg.sv
// ----------------------------------------------------------------------------
// lgp_pkg: shared constants and types
// Sizes and the memory-address type of the progression engine.
// ----------------------------------------------------------------------------
`default_nettype none
package lgp_pkg;
    localparam int MaxElements = 64;
    localparam int ValueWidth  = 16;
    localparam int IdxWidth    = $clog2(MaxElements);
    localparam int CntWidth    = $clog2(MaxElements + 1);
    localparam int LenWidth    = 7;
    localparam int ProdWidth   = 2 * ValueWidth;
    localparam logic [LenWidth-1:0] LenMax = 7'd127;

    typedef logic [IdxWidth-1:0]   idx_t;
    typedef logic [CntWidth-1:0]   cnt_t;
    typedef logic [ValueWidth-1:0] val_t;
    typedef logic [LenWidth-1:0]   len_t;
    typedef logic [ProdWidth-1:0]  prod_t;
endpackage
`default_nettype wire

FILE: rtl/core/lgp_divider.sv
// ----------------------------------------------------------------------------
// lgp_divider: bit-serial divisibility test
// Restoring division, one quotient bit a cycle; reports remainder zero.
// ----------------------------------------------------------------------------
`default_nettype none
module lgp_divider
    import lgp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire val_t dividend,
    input  wire val_t divisor,
    output logic      done,
    output logic      divisible
);
    localparam int StepWidth = $clog2(ValueWidth + 1);

    logic [ValueWidth:0]    rem_reg, rem_next;
    val_t                   quo_reg, quo_next;
    val_t                   dsr_reg, dsr_next;
    logic [StepWidth-1:0]   step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ValueWidth:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            step_next = StepWidth'(ValueWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[ValueWidth-1:0], quo_reg[ValueWidth-1]};
            quo_next = {quo_reg[ValueWidth-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = trial - {1'b0, dsr_reg};
            else
                rem_next = trial;
            step_next = step_reg - 1'b1;
            if (step_reg == StepWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign divisible = (dsr_reg != '0) && (rem_reg == '0);

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("divider done held");
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg)) else $error("divider done without work");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/longest_geometric_progression_unit.sv
// ----------------------------------------------------------------------------
// longest_geometric_progression_unit: longest integer-ratio progression
// Loads a set, insertion-sorts it, fills the pair table and emits the length.
// ----------------------------------------------------------------------------
//  channel  signals                   direction
//  request  valid, stall, value, last in
//  result   out_valid, out_stall, length  out
//
// Loading accepts one element per cycle. On the last element of a set of two
// or more the block runs an insertion sort and a pair-table fill: for each pair
// it reads the values, multiplies them and runs the divisibility test in the
// shared serial divider, with further steps for pointer advances, matching
// products and column starts. Stall stays high until the result is taken.
// Reset clears control and working registers only; the stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module longest_geometric_progression_unit
    import lgp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic valid,
    output logic      stall,
    input  wire val_t value,
    input  wire logic last,
    output logic      out_valid,
    input  wire logic out_stall,
    output len_t      length
);
    typedef enum logic [4:0] {
        S_LOAD, S_SORT_RD, S_SORT_CMP, S_SORT_DONE,
        S_COL_INIT, S_LASTCOL_RD, S_LASTCOL_DIV, S_LASTCOL_WAIT,
        S_COL_START, S_PAIR_RD, S_PAIR_MUL, S_PAIR_CMP,
        S_DIV_WAIT, S_TAB_RD, S_TAB_WR, S_REST_RD, S_REST_DIV, S_REST_WAIT,
        S_OUT, S_RD_WAIT
    } state_t;

    val_t mem [MaxElements];
    len_t tab [MaxElements*MaxElements];

    state_t state_reg;
    state_t ret_reg;
    cnt_t   count_reg;
    len_t   best_reg;
    idx_t   p_reg, q_reg, i_reg, j_reg, k_reg;
    logic   ineg_reg;
    val_t   v_reg, a_reg, b_reg, rd_reg;
    prod_t  prod_reg, sq_reg;
    len_t   tab_rd_reg;
    logic   out_valid_reg;
    len_t   length_reg;

    logic   div_start;
    val_t   div_dvd, div_dsr;
    logic   div_done, div_ok;

    lgp_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_dvd), .divisor(div_dsr),
        .done(div_done), .divisible(div_ok)
    );

    assign div_dvd = b_reg;
    assign div_dsr = a_reg;
    assign div_start = (state_reg == S_PAIR_CMP) && (ineg_reg || prod_reg >= sq_reg);

    idx_t  nm1;
    assign nm1 = idx_t'(count_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[q_reg];
        tab_rd_reg <= tab[{j_reg, k_reg}];
        case (state_reg)
            S_LOAD:
                if (valid && count_reg < cnt_t'(MaxElements))
                    mem[idx_t'(count_reg)] <= value;
            S_SORT_CMP:
                if (!ineg_reg && rd_reg > v_reg)
                    mem[idx_t'(q_reg + 1'b1)] <= rd_reg;
                else
                    mem[idx_t'(q_reg + idx_t'(!ineg_reg))] <= v_reg;
            S_LASTCOL_WAIT, S_REST_WAIT:
                if (div_done)
                    tab[{i_reg, j_reg}] <= div_ok ? len_t'(2) : len_t'(1);
            S_DIV_WAIT:
                if (div_done)
                    tab[{i_reg, j_reg}] <= div_ok ? len_t'(2) : len_t'(1);
            S_TAB_WR:
                tab[{i_reg, j_reg}] <= div_ok ? tab_rd_reg + 1'b1 : len_t'(1);
            default: ;
        endcase
    end

    logic div_ok_reg;
    logic equal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            ret_reg       <= S_LOAD;
            count_reg     <= '0;
            best_reg      <= len_t'(1);
            out_valid_reg <= 1'b0;
            length_reg    <= len_t'(1);
            p_reg <= '0; q_reg <= '0; i_reg <= '0; j_reg <= '0; k_reg <= '0;
            ineg_reg <= 1'b0;
            v_reg <= '0; a_reg <= '0; b_reg <= '0;
            prod_reg <= '0; sq_reg <= '0;
            div_ok_reg <= 1'b0; equal_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                    if (valid)
                    begin
                        cnt_t n;
                        n = (count_reg < cnt_t'(MaxElements)) ? count_reg + 1'b1 : count_reg;
                        count_reg <= n;
                        if (last)
                        begin
                            best_reg <= len_t'(1);
                            if (n < cnt_t'(2))
                            begin
                                length_reg <= len_t'(1);
                                out_valid_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                p_reg <= idx_t'(1);
                                q_reg <= idx_t'(1);
                                ret_reg <= S_SORT_RD;
                                state_reg <= S_RD_WAIT;
                            end
                        end
                    end
                S_RD_WAIT:
                    state_reg <= ret_reg;
                S_SORT_RD:
                begin
                    // rd_reg now holds mem[p]
                    v_reg <= rd_reg;
                    q_reg <= p_reg - 1'b1;
                    ineg_reg <= 1'b0;
                    state_reg <= S_SORT_DONE;
                end
                S_SORT_DONE:
                    state_reg <= S_SORT_CMP;
                S_SORT_CMP:
                    if (!ineg_reg && rd_reg > v_reg)
                    begin
                        if (q_reg == '0)
                            ineg_reg <= 1'b1;
                        else
                            q_reg <= q_reg - 1'b1;
                        state_reg <= S_SORT_DONE;
                    end
                    else if (cnt_t'(p_reg) + 1'b1 >= count_reg)
                        state_reg <= S_COL_INIT;
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                        q_reg <= p_reg + 1'b1;
                        ret_reg <= S_SORT_RD;
                        state_reg <= S_RD_WAIT;
                    end
                S_COL_INIT:
                begin
                    j_reg <= nm1;
                    i_reg <= '0;
                    q_reg <= nm1;
                    ret_reg <= S_LASTCOL_RD;
                    state_reg <= S_RD_WAIT;
                end
                S_LASTCOL_RD:
                begin
                    b_reg <= rd_reg;
                    q_reg <= i_reg;
                    ret_reg <= S_PAIR_RD;
                    state_reg <= S_RD_WAIT;
                    k_reg <= '0;
                    ineg_reg <= 1'b1;
                end
                S_LASTCOL_DIV:
                    state_reg <= S_LASTCOL_WAIT;
                S_LASTCOL_WAIT, S_REST_WAIT, S_DIV_WAIT:
                    if (div_done)
                    begin
                        div_ok_reg <= div_ok;
                        if (equal_reg)
                        begin
                            q_reg <= k_reg;
                            state_reg <= S_TAB_RD;
                        end
                        else
                        begin
                            if (div_ok && best_reg < len_t'(2))
                                best_reg <= len_t'(2);
                            if (state_reg == S_LASTCOL_WAIT)
                            begin
                                if (i_reg == nm1 - 1'b1)
                                    state_reg <= S_COL_START;
                                else
                                begin
                                    i_reg <= i_reg + 1'b1;
                                    q_reg <= i_reg + 1'b1;
                                    ret_reg <= S_PAIR_RD;
                                    state_reg <= S_RD_WAIT;
                                end
                            end
                            else if (i_reg == '0)
                                state_reg <= S_COL_START;
                            else
                            begin
                                i_reg <= i_reg - 1'b1;
                                q_reg <= i_reg - 1'b1;
                                ret_reg <= S_PAIR_RD;
                                state_reg <= S_RD_WAIT;
                            end
                        end
                    end
                S_TAB_RD:
                    state_reg <= S_TAB_WR;
                S_TAB_WR:
                begin
                    if (div_ok_reg && tab_rd_reg + 1'b1 > best_reg)
                        best_reg <= tab_rd_reg + 1'b1;
                    equal_reg <= 1'b0;
                    if (i_reg == '0)
                        state_reg <= S_COL_START;
                    else
                    begin
                        i_reg <= i_reg - 1'b1;
                        q_reg <= i_reg - 1'b1;
                        if (k_reg != nm1)
                            k_reg <= k_reg + 1'b1;
                        else
                            ineg_reg <= 1'b1;
                        ret_reg <= S_PAIR_RD;
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_COL_START:
                begin
                    ineg_reg <= 1'b0;
                    if (state_reg == S_COL_START && j_reg == idx_t'(1))
                    begin
                        length_reg <= best_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg <= j_reg - 1'b1;
                        q_reg <= j_reg - 1'b1;
                        i_reg <= j_reg - idx_t'(2);
                        k_reg <= j_reg;
                        state_reg <= S_REST_RD;
                    end
                end
                S_REST_RD:
                    state_reg <= S_REST_DIV;
                S_REST_DIV:
                begin
                    b_reg <= rd_reg;
                    q_reg <= i_reg;
                    ret_reg <= S_PAIR_RD;
                    state_reg <= S_RD_WAIT;
                end
                S_PAIR_RD:
                begin
                    a_reg <= rd_reg;
                    q_reg <= k_reg;
                    ret_reg <= S_PAIR_MUL;
                    state_reg <= S_RD_WAIT;
                end
                S_PAIR_MUL:
                begin
                    prod_reg <= prod_t'(a_reg) * prod_t'(rd_reg);
                    sq_reg <= prod_t'(b_reg) * prod_t'(b_reg);
                    state_reg <= S_PAIR_CMP;
                end
                S_PAIR_CMP:
                begin
                    if (!ineg_reg && prod_reg < sq_reg)
                    begin
                        if (k_reg == nm1)
                        begin
                            ineg_reg <= 1'b1;
                            state_reg <= S_PAIR_CMP;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            q_reg <= k_reg + 1'b1;
                            ret_reg <= S_PAIR_MUL;
                            state_reg <= S_RD_WAIT;
                        end
                    end
                    else
                    begin
                        equal_reg <= !ineg_reg && prod_reg == sq_reg;
                        state_reg <= (j_reg == nm1) ? S_LASTCOL_WAIT : S_DIV_WAIT;
                    end
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        count_reg <= '0;
                        best_reg <= len_t'(1);
                        state_reg <= S_LOAD;
                    end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    assign stall     = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;
    assign length    = length_reg;

`ifndef SYNTH
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("result outside output state");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stall) else $error("request taken while result waits");
    a_best_pos: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg != '0) else $error("best length zero");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MaxElements)) else $error("count overflow");
`endif
endmodule
`default_nettype wire
